[rtl/core/vpa_pkg.sv]
// Shared types and constants for the variable partition allocator.
package vpa_pkg;

	localparam logic [1:0] OP_ENQ   = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_GRANT = 2'd1;
	localparam logic [1:0] ST_NOFIT = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_NEXT  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic REG_FIT_POLICY  = 1'b0;
	localparam logic REG_MEMORY_SIZE = 1'b1;

	localparam logic [15:0] MEM_SIZE_RESET = 16'd1024;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENQ,
		S_SEARCH,
		S_RESOLVE,
		S_COMMIT,
		S_TICK,
		S_MINIT,
		S_MERGE,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_ACCEPT,
		CMD_ENQ,
		CMD_SEARCH,
		CMD_RESOLVE,
		CMD_COMMIT,
		CMD_TICK,
		CMD_MINIT,
		CMD_MERGE,
		CMD_MFIN,
		CMD_EMIT
	} cmd_t;

	typedef struct packed {
		logic q_empty;
		logic search_last;
		logic commit_ok;
		logic tick_last;
		logic merge_end;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/core/variable_partition_allocator_core.sv]
// Top level of the variable partition allocator.
//
//  channel  signals                                          dir
//  in       in_valid in_stall opcode request_size hold_seconds  input word
//  out      out_valid out_stall status grant_start grant_size   output word
//           freed_count queue_count
//  cfg      cfg_write cfg_index cfg_data                      register write
//
// An enqueue passes the enqueue step; an unused opcode or an allocate with an empty queue
// goes straight to the final step. An allocate scans up to region_count regions, resolves
// and, if it fits, commits and runs a merge pass; a tick ages all regions, then merges.
// After reset the table holds one free region of 1024 units.
// The next input word is taken while a result word waits under out_stall; its own result
// then waits in the final step until the output register is free.
module variable_partition_allocator_core #(
	parameter int MAX_REGIONS = 32,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] request_size,
	input  logic [7:0]  hold_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] grant_start,
	output logic [15:0] grant_size,
	output logic [5:0]  freed_count,
	output logic [4:0]  queue_count,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import vpa_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	vpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	vpa_dp #(
		.MAX_REGIONS (MAX_REGIONS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.request_size (request_size),
		.hold_seconds (hold_seconds),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.grant_start  (grant_start),
		.grant_size   (grant_size),
		.freed_count  (freed_count),
		.queue_count  (queue_count)
	);

endmodule

[rtl/core/vpa_ctrl.sv]
// Sequencing state machine of the variable partition allocator.
module vpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        opcode,
	input  vpa_pkg::dp_stat_t stat,
	output vpa_pkg::cmd_t     cmd,
	output logic              in_stall
);
	import vpa_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (opcode)
						OP_ENQ:   state_nx = S_ENQ;
						OP_ALLOC: state_nx = stat.q_empty ? S_EMIT : S_SEARCH;
						OP_TICK:  state_nx = S_TICK;
						default:  state_nx = S_EMIT;
					endcase
				end
			end
			S_ENQ:     state_nx = S_EMIT;
			S_SEARCH:  state_nx = stat.search_last ? S_RESOLVE : S_SEARCH;
			S_RESOLVE: state_nx = stat.commit_ok ? S_COMMIT : S_EMIT;
			S_COMMIT:  state_nx = S_MINIT;
			S_TICK:    state_nx = stat.tick_last ? S_MINIT : S_TICK;
			S_MINIT:   state_nx = S_MERGE;
			S_MERGE:   state_nx = stat.merge_end ? S_EMIT : S_MERGE;
			S_EMIT:    state_nx = stat.out_free ? S_IDLE : S_EMIT;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = CMD_NOP;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd      = in_valid ? CMD_ACCEPT : CMD_NOP;
			end
			S_ENQ:     cmd = CMD_ENQ;
			S_SEARCH:  cmd = CMD_SEARCH;
			S_RESOLVE: cmd = CMD_RESOLVE;
			S_COMMIT:  cmd = CMD_COMMIT;
			S_TICK:    cmd = CMD_TICK;
			S_MINIT:   cmd = CMD_MINIT;
			S_MERGE:   cmd = stat.merge_end ? CMD_MFIN : CMD_MERGE;
			S_EMIT:    cmd = stat.out_free ? CMD_EMIT : CMD_NOP;
			default:   cmd = CMD_NOP;
		endcase
	end

endmodule

[rtl/core/vpa_dp.sv]
// Region table, request queue, scan counters and result register.
module vpa_dp #(
	parameter int MAX_REGIONS = 32,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vpa_pkg::cmd_t     cmd,
	output vpa_pkg::dp_stat_t stat,
	input  logic [1:0]        opcode,
	input  logic [15:0]       request_size,
	input  logic [7:0]        hold_seconds,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [15:0]       grant_start,
	output logic [15:0]       grant_size,
	output logic [5:0]        freed_count,
	output logic [4:0]        queue_count
);
	import vpa_pkg::*;

	localparam int IW  = $clog2(MAX_REGIONS);
	localparam int CW  = $clog2(MAX_REGIONS + 1);
	localparam int QIW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	logic [15:0] rs_q [MAX_REGIONS];
	logic [15:0] rl_q [MAX_REGIONS];
	logic        ru_q [MAX_REGIONS];
	logic [7:0]  rh_q [MAX_REGIONS];
	logic [7:0]  re_q [MAX_REGIONS];
	logic [CW-1:0] rc_q;
	logic [15:0] ps_q [QUEUE_DEPTH];
	logic [7:0]  ph_q [QUEUE_DEPTH];
	logic [QIW-1:0] qh_q;
	logic [QIW-1:0] qt_q;
	logic [QCW-1:0] pc_q;
	logic [IW-1:0]  nfi_q;
	logic [1:0]  fit_q;
	logic [15:0] size_q;
	logic [7:0]  hold_q;
	logic [1:0]  st_q;
	logic [15:0] gs_q;
	logic [15:0] gz_q;
	logic [5:0]  fr_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] k_q;
	logic        fnd_q;
	logic [IW-1:0] fi_q;
	logic [15:0] fs_q;
	logic [15:0] fl_q;
	logic        pu_q;
	logic [15:0] pl_q;

	logic [15:0] cur_s;
	logic [15:0] cur_l;
	logic        cur_u;
	logic [7:0]  cur_h;
	logic [7:0]  cur_e;
	logic [15:0] req_sz;
	logic [7:0]  req_hold;
	logic        worst;
	logic        hit;
	logic        better;
	logic        split;
	logic        full;
	logic        mfree;
	logic [CW-1:0] idx_inc;
	logic [IW-1:0] idx_wrap;
	logic [CW-1:0] fi_inc;
	logic [CW-1:0] rc_new;
	logic        out_free;

	assign cur_s    = rs_q[idx_q];
	assign cur_l    = rl_q[idx_q];
	assign cur_u    = ru_q[idx_q];
	assign cur_h    = rh_q[idx_q];
	assign cur_e    = re_q[idx_q];
	assign req_sz   = ps_q[qh_q];
	assign req_hold = ph_q[qh_q];
	assign worst    = (fit_q == FIT_WORST);
	assign hit      = !cur_u && (cur_l >= req_sz);
	assign better   = hit && (!fnd_q || (cur_l > fl_q));
	assign split    = (fl_q > req_sz);
	assign full     = (rc_q >= CW'(MAX_REGIONS));
	assign mfree    = !pu_q && !cur_u;
	assign idx_inc  = CW'(idx_q) + CW'(1);
	assign idx_wrap = (idx_inc >= rc_q) ? '0 : idx_inc[IW-1:0];
	assign fi_inc   = CW'(fi_q) + CW'(1);
	assign rc_new   = rc_q + CW'(split);
	assign out_free = !out_valid || !out_stall;

	assign stat.q_empty     = (pc_q == '0);
	assign stat.search_last = (k_q == rc_q - CW'(1)) || (hit && !worst);
	assign stat.commit_ok   = fnd_q && !(split && full);
	assign stat.tick_last   = (k_q == rc_q - CW'(1));
	assign stat.merge_end   = (k_q >= rc_q);
	assign stat.out_free    = out_free;

	// Region table: start, length and used bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MAX_REGIONS; m++) begin
				rs_q[m] <= '0;
				rl_q[m] <= '0;
				ru_q[m] <= 1'b0;
			end
			rl_q[0] <= MEM_SIZE_RESET;
		end else if (cfg_write && (cfg_index == REG_MEMORY_SIZE)) begin
			rs_q[0] <= '0;
			rl_q[0] <= cfg_data;
			ru_q[0] <= 1'b0;
		end else begin
			for (int m = 0; m < MAX_REGIONS; m++) begin
				case (cmd)
					CMD_COMMIT: begin
						if (split && (m > 0) && (CW'(m) > fi_inc) && (CW'(m) <= rc_q)) begin
							rs_q[m] <= rs_q[(m > 0) ? m - 1 : m];
							rl_q[m] <= rl_q[(m > 0) ? m - 1 : m];
							ru_q[m] <= ru_q[(m > 0) ? m - 1 : m];
						end else if (split && (CW'(m) == fi_inc)) begin
							rs_q[m] <= fs_q + req_sz;
							rl_q[m] <= fl_q - req_sz;
							ru_q[m] <= 1'b0;
						end else if (IW'(m) == fi_q) begin
							rl_q[m] <= req_sz;
							ru_q[m] <= 1'b1;
						end
					end
					CMD_TICK: begin
						if ((IW'(m) == idx_q) && cur_u && (cur_e >= cur_h)) begin
							ru_q[m] <= 1'b0;
						end
					end
					CMD_MERGE: begin
						if (mfree) begin
							if (CW'(m) + CW'(1) == k_q) begin
								rl_q[m] <= pl_q + cur_l;
							end else if ((m < MAX_REGIONS - 1) && (CW'(m) >= k_q)
								&& (CW'(m) + CW'(1) < rc_q)) begin
								rs_q[m] <= rs_q[(m < MAX_REGIONS - 1) ? m + 1 : m];
								rl_q[m] <= rl_q[(m < MAX_REGIONS - 1) ? m + 1 : m];
								ru_q[m] <= ru_q[(m < MAX_REGIONS - 1) ? m + 1 : m];
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Region table: hold and elapsed times.
	always_ff @(posedge clk) begin
		for (int m = 0; m < MAX_REGIONS; m++) begin
			case (cmd)
				CMD_COMMIT: begin
					if (split && (m > 0) && (CW'(m) > fi_inc) && (CW'(m) <= rc_q)) begin
						rh_q[m] <= rh_q[(m > 0) ? m - 1 : m];
						re_q[m] <= re_q[(m > 0) ? m - 1 : m];
					end else if (split && (CW'(m) == fi_inc)) begin
						rh_q[m] <= '0;
						re_q[m] <= '0;
					end else if (IW'(m) == fi_q) begin
						rh_q[m] <= req_hold;
						re_q[m] <= '0;
					end
				end
				CMD_TICK: begin
					if ((IW'(m) == idx_q) && cur_u && (cur_e < cur_h)) begin
						re_q[m] <= cur_e + 8'd1;
					end
				end
				CMD_MERGE: begin
					if (mfree && (m < MAX_REGIONS - 1) && (CW'(m) >= k_q)
						&& (CW'(m) + CW'(1) < rc_q)) begin
						rh_q[m] <= rh_q[(m < MAX_REGIONS - 1) ? m + 1 : m];
						re_q[m] <= re_q[(m < MAX_REGIONS - 1) ? m + 1 : m];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Pending request storage.
	always_ff @(posedge clk) begin
		if ((cmd == CMD_ENQ) && (pc_q < QCW'(QUEUE_DEPTH)) && (size_q != '0)) begin
			ps_q[qt_q] <= size_q;
			ph_q[qt_q] <= hold_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q      <= CW'(1);
			qh_q      <= '0;
			qt_q      <= '0;
			pc_q      <= '0;
			nfi_q     <= '0;
			fit_q     <= FIT_FIRST;
			out_valid <= 1'b0;
		end else begin
			if (cmd == CMD_EMIT) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (cfg_write) begin
				if (cfg_index == REG_FIT_POLICY) begin
					fit_q <= cfg_data[1:0];
				end else begin
					rc_q  <= CW'(1);
					nfi_q <= '0;
				end
			end else begin
				case (cmd)
					CMD_ENQ: begin
						if ((pc_q < QCW'(QUEUE_DEPTH)) && (size_q != '0)) begin
							qt_q <= (qt_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : qt_q + QIW'(1);
							pc_q <= pc_q + QCW'(1);
						end
					end
					CMD_COMMIT: begin
						rc_q  <= rc_new;
						qh_q  <= (qh_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : qh_q + QIW'(1);
						pc_q  <= pc_q - QCW'(1);
						nfi_q <= (fi_inc >= rc_new) ? '0 : fi_inc[IW-1:0];
					end
					CMD_MERGE: begin
						if (mfree) begin
							rc_q <= rc_q - CW'(1);
							if (CW'(nfi_q) >= k_q) begin
								nfi_q <= nfi_q - IW'(1);
							end
						end
					end
					CMD_MFIN: begin
						if (CW'(nfi_q) >= rc_q) begin
							nfi_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Item, scan and result registers.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				size_q <= request_size;
				hold_q <= hold_seconds;
				st_q   <= ((opcode == OP_ALLOC) && (pc_q == '0)) ? ST_NOFIT : ST_DONE;
				gs_q   <= '0;
				gz_q   <= '0;
				fr_q   <= '0;
				k_q    <= '0;
				fnd_q  <= 1'b0;
				idx_q  <= ((opcode == OP_ALLOC) && (fit_q == FIT_NEXT)
					&& (CW'(nfi_q) < rc_q)) ? nfi_q : '0;
			end
			CMD_ENQ: begin
				if (pc_q >= QCW'(QUEUE_DEPTH)) begin
					st_q <= ST_FULL;
				end else if (size_q == '0) begin
					st_q <= ST_NOFIT;
				end
			end
			CMD_SEARCH: begin
				if (worst ? better : (hit && !fnd_q)) begin
					fnd_q <= 1'b1;
					fi_q  <= idx_q;
					fs_q  <= cur_s;
					fl_q  <= cur_l;
				end
				k_q   <= k_q + CW'(1);
				idx_q <= idx_wrap;
			end
			CMD_RESOLVE: begin
				if (!fnd_q) begin
					st_q <= ST_NOFIT;
				end else if (split && full) begin
					st_q <= ST_FULL;
				end
			end
			CMD_COMMIT: begin
				st_q <= ST_GRANT;
				gs_q <= fs_q;
				gz_q <= req_sz;
			end
			CMD_TICK: begin
				if (cur_u && (cur_e >= cur_h)) begin
					fr_q <= fr_q + 6'd1;
				end
				k_q   <= k_q + CW'(1);
				idx_q <= idx_inc[IW-1:0];
			end
			CMD_MINIT: begin
				pu_q  <= ru_q[0];
				pl_q  <= rl_q[0];
				k_q   <= CW'(1);
				idx_q <= IW'(1);
			end
			CMD_MERGE: begin
				if (mfree) begin
					pl_q <= pl_q + cur_l;
				end else begin
					pu_q  <= cur_u;
					pl_q  <= cur_l;
					k_q   <= k_q + CW'(1);
					idx_q <= idx_inc[IW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output word.
	always_ff @(posedge clk) begin
		if (cmd == CMD_EMIT) begin
			status      <= st_q;
			grant_start <= gs_q;
			grant_size  <= gz_q;
			freed_count <= fr_q;
			queue_count <= 5'(pc_q);
		end
	end

endmodule
